// ----- rtl/lossm_pkg.sv -----
// Shared types and constants for the last-occurrence substring matcher.
package lossm_pkg;

    // Window and text limits.
    localparam int PATTERN_MAX = 16;
    localparam int TEXT_MAX    = 65536;
    localparam int IDX_W       = $clog2(TEXT_MAX + 1);
    localparam int POS_W       = 16;
    localparam int LEN_W       = 5;
    localparam int SEL_W       = $clog2(PATTERN_MAX);
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PAT_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd2;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Output stream width: found, match_position, overflow, padded to bytes.
    localparam int OUT_BITS = 1 + POS_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // One classified byte as passed from the front to the back.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic             ovf;
        logic             last;
    } rec_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/lossm_front.sv -----
// Front part: byte window, byte counter and parallel pattern compare.
module lossm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [7:0]                     text_byte,
    input  logic                           last_byte,
    input  logic [8*lossm_pkg::PATTERN_MAX-1:0] pattern,
    input  logic [lossm_pkg::LEN_W-1:0]    pattern_len,
    output lossm_pkg::rec_t                rec
);

    logic [7:0] win_reg  [lossm_pkg::PATTERN_MAX];
    logic [7:0] win_next [lossm_pkg::PATTERN_MAX];
    logic [7:0] shifted  [lossm_pkg::PATTERN_MAX];
    logic [lossm_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic ovf_reg, ovf_next;
    logic at_limit;
    logic mismatch;
    logic len_ok;
    logic [lossm_pkg::IDX_W-1:0] start_full;
    logic [lossm_pkg::LEN_W-1:0] len_m1;

    // Window after this byte is shifted in; entry 0 is the newest byte.
    always_comb begin
        shifted[0] = text_byte;
        for (int k = 1; k < lossm_pkg::PATTERN_MAX; k++) begin
            shifted[k] = win_reg[k-1];
        end
    end

    assign at_limit = (idx_reg >= lossm_pkg::IDX_W'(lossm_pkg::TEXT_MAX));
    assign len_m1   = pattern_len - lossm_pkg::LEN_W'(1);
    assign len_ok   = (pattern_len != '0) &&
                      (pattern_len <= lossm_pkg::LEN_W'(lossm_pkg::PATTERN_MAX));

    // Window position p holds pattern byte len-1-p; all positions compare at once.
    always_comb begin
        logic [lossm_pkg::LEN_W-1:0] sel;
        mismatch = 1'b0;
        for (int p = 0; p < lossm_pkg::PATTERN_MAX; p++) begin
            sel = len_m1 - lossm_pkg::LEN_W'(p);
            if (lossm_pkg::LEN_W'(p) < pattern_len) begin
                if (shifted[p] != pattern[8*sel[lossm_pkg::SEL_W-1:0] +: 8]) begin
                    mismatch = 1'b1;
                end
            end
        end
    end

    // Start index of a hit on this byte, saturated to the position width.
    assign start_full = idx_reg + lossm_pkg::IDX_W'(1) - lossm_pkg::IDX_W'(pattern_len);

    always_comb begin
        rec.hit  = !at_limit && len_ok && !mismatch &&
                   (idx_reg >= lossm_pkg::IDX_W'(len_m1));
        if (start_full > lossm_pkg::IDX_W'({lossm_pkg::POS_W{1'b1}})) begin
            rec.pos = {lossm_pkg::POS_W{1'b1}};
        end else begin
            rec.pos = start_full[lossm_pkg::POS_W-1:0];
        end
        rec.ovf  = ovf_reg || at_limit;
        rec.last = last_byte;
    end

    // Text state: clears after the last byte, holds once the limit is reached.
    always_comb begin
        win_next = win_reg;
        idx_next = idx_reg;
        ovf_next = ovf_reg;
        if (accept) begin
            if (last_byte) begin
                for (int k = 0; k < lossm_pkg::PATTERN_MAX; k++) begin
                    win_next[k] = '0;
                end
                idx_next = '0;
                ovf_next = 1'b0;
            end else if (at_limit) begin
                ovf_next = 1'b1;
            end else begin
                win_next = shifted;
                idx_next = idx_reg + lossm_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < lossm_pkg::PATTERN_MAX; k++) begin
                win_reg[k] <= '0;
            end
            idx_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            win_reg <= win_next;
            idx_reg <= idx_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// ----- rtl/lossm_queue.sv -----
// Short queue of classified bytes between the front and the back.
module lossm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lossm_pkg::rec_t    push_rec,
    input  logic               pop,
    output lossm_pkg::rec_t    head_rec,
    output lossm_pkg::q_stat_t stat
);

    lossm_pkg::rec_t mem_reg [lossm_pkg::Q_DEPTH];
    logic [lossm_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lossm_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lossm_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == lossm_pkg::Q_CNT_W'(lossm_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + lossm_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + lossm_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + lossm_pkg::Q_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - lossm_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // The fill count never goes past the depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= lossm_pkg::Q_CNT_W'(lossm_pkg::Q_DEPTH))
        else $error("queue count above depth");

    // Nothing is taken from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    // Nothing is written into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("push into full queue");

    // A push without a pop grows the count by one.
    a_cnt_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + lossm_pkg::Q_CNT_W'(1)))
        else $error("queue count did not grow");

endmodule

// ----- rtl/lossm_back.sv -----
// Back part: keeps the last hit of a text and issues the result transaction.
module lossm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lossm_pkg::rec_t               head_rec,
    input  lossm_pkg::q_stat_t            stat,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lossm_pkg::OUT_W-1:0]   m_tdata
);

    logic seen_reg, seen_next;
    logic [lossm_pkg::POS_W-1:0] pos_reg, pos_next;
    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;
    logic [lossm_pkg::POS_W-1:0] out_pos_reg, out_pos_next;
    logic out_ovf_reg, out_ovf_next;

    // A record that ends a text waits until the output register is free.
    assign pop = !stat.empty &&
                 (!head_rec.last || !out_valid_reg || m_tready);

    always_comb begin
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        out_ovf_next   = out_ovf_reg;
        if (pop) begin
            if (head_rec.last) begin
                out_valid_next = 1'b1;
                out_found_next = seen_reg || head_rec.hit;
                out_ovf_next   = head_rec.ovf;
                if (head_rec.hit) begin
                    out_pos_next = head_rec.pos;
                end else if (seen_reg) begin
                    out_pos_next = pos_reg;
                end else begin
                    out_pos_next = '0;
                end
                seen_next = 1'b0;
                pos_next  = '0;
            end else if (head_rec.hit) begin
                seen_next = 1'b1;
                pos_next  = head_rec.pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lossm_pkg::OUT_W - lossm_pkg::OUT_BITS){1'b0}},
                       out_ovf_reg, out_pos_reg, out_found_reg};

    // The end of a text always leaves the hit tracker cleared.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_rec.last) |=> (!seen_reg && pos_reg == '0))
        else $error("hit tracker not cleared after text end");

    // A result is only loaded when the previous one has left or is leaving.
    a_no_result_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_rec.last && out_valid_reg) |-> m_tready)
        else $error("result overwritten before it was taken");

    // A result that reports no match carries position zero.
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_pos_reg == '0))
        else $error("not-found result with nonzero position");

endmodule

// ----- rtl/last_occurrence_substring_matcher_unit.sv -----
// Top level of the last-occurrence substring matcher.
// The block takes one text byte per cycle at full rate: the front compares the
// newest window against the configured pattern combinationally and passes a
// per-byte record through a four-entry queue to the back, which tracks the last
// hit and registers the result. The record of the byte that ends the text is held
// in the queue before the back loads the result register; a stalled result stops
// the back only, and the front keeps taking bytes until the queue fills.
// Configuration writes are taken at any time and are meant to be made between texts.
module last_occurrence_substring_matcher_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Text input: s_tdata = text_byte; s_tlast = last_byte.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    // Result output: m_tdata = found, match_position[15:0], overflow, zero pad.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lossm_pkg::OUT_W-1:0]       m_tdata,
    // Configuration writes.
    input  logic                              cfg_wr_en,
    input  logic [lossm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lossm_pkg::CFG_W-1:0]       cfg_wdata
);

    logic [lossm_pkg::CFG_W-1:0] pat_first_reg;
    logic [lossm_pkg::CFG_W-1:0] pat_last_reg;
    logic [lossm_pkg::LEN_W-1:0] pat_len_reg;
    logic accept;
    logic pop;
    lossm_pkg::rec_t    front_rec;
    lossm_pkg::rec_t    head_rec;
    lossm_pkg::q_stat_t q_stat;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_first_reg <= '0;
            pat_last_reg  <= '0;
            pat_len_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lossm_pkg::REG_PAT_FIRST: pat_first_reg <= cfg_wdata;
                lossm_pkg::REG_PAT_LAST:  pat_last_reg  <= cfg_wdata;
                lossm_pkg::REG_PAT_LEN:   pat_len_reg   <= cfg_wdata[lossm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    lossm_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .text_byte   (s_tdata),
        .last_byte   (s_tlast),
        .pattern     ({pat_last_reg, pat_first_reg}),
        .pattern_len (pat_len_reg),
        .rec         (front_rec)
    );

    lossm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_rec (front_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .stat     (q_stat)
    );

    lossm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .stat     (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- bench/tb_last_occurrence_substring_matcher_unit.sv -----
// Self-checking testbench for the last-occurrence substring matcher unit.
module tb_last_occurrence_substring_matcher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_BYTES  = 1700;
    localparam int SETTLE_CYCLES = 6;
    localparam int DIR_ROWS      = 7;

    // One text result: found flag, start of the last hit, overflow flag.
    typedef struct packed {
        logic                        found;
        logic [lossm_pkg::POS_W-1:0] pos;
        logic                        ovf;
    } match_t;

    // One directed text with the pattern it runs against.
    typedef struct packed {
        logic                        wr;
        logic [63:0]                 lo;
        logic [63:0]                 hi;
        logic [lossm_pkg::LEN_W-1:0] len;
        logic [4:0]                  n;
        logic [127:0]                text;
        logic                        typed;
        match_t                      want;
    } dir_row_t;

    // Directed texts; the result is typed in where it is obvious.
    dir_row_t dir_rows [DIR_ROWS] = '{
        // Pattern registers still at their reset values.
        '{1'b0, 64'h0, 64'h0, 5'd0, 5'd1, 128'h00, 1'b1, '{1'b0, 16'd0, 1'b0}},
        // Single zero byte, hit twice: the later start is kept.
        '{1'b1, 64'h0, 64'h0, 5'd1, 5'd3, 128'h00_FF_00, 1'b1, '{1'b1, 16'd2, 1'b0}},
        // Two back-to-back hits of a two-byte pattern.
        '{1'b1, 64'h4241, 64'h0, 5'd2, 5'd4, 128'h42_41_42_41, 1'b0, '{1'b0, 16'd0, 1'b0}},
        // Full sixteen-byte pattern of all ones.
        '{1'b1, {64{1'b1}}, {64{1'b1}}, 5'd16, 5'd16, {128{1'b1}}, 1'b1,
          '{1'b1, 16'd0, 1'b0}},
        // Pattern longer than the text.
        '{1'b1, 64'h03_02_01, 64'h0, 5'd3, 5'd2, 128'h02_01, 1'b1, '{1'b0, 16'd0, 1'b0}},
        // Zero length never matches, even when the byte equals the pattern.
        '{1'b1, 64'h5A, 64'h0, 5'd0, 5'd1, 128'h5A, 1'b1, '{1'b0, 16'd0, 1'b0}},
        // Length above the window size never matches.
        '{1'b1, 64'h0, 64'h0, 5'd31, 5'd1, 128'h00, 1'b1, '{1'b0, 16'd0, 1'b0}}
    };

    // Block ports.
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = 8'h00;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lossm_pkg::OUT_W-1:0]     m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [lossm_pkg::CFG_IDX_W-1:0] cfg_index = lossm_pkg::REG_PAT_FIRST;
    logic [lossm_pkg::CFG_W-1:0]     cfg_wdata = '0;

    // Predictor copy of the configuration and the per-text search state.
    logic [63:0]                 cfg_lo;
    logic [63:0]                 cfg_hi;
    logic [lossm_pkg::LEN_W-1:0] cfg_len;
    logic [7:0]                  recent [lossm_pkg::PATTERN_MAX];
    int                          searched;
    int                          last_start;
    bit                          hit_seen;
    bit                          text_ovf;

    // Stimulus buffers.
    logic [7:0] txt [64];
    logic [7:0] pat_b [16];
    logic [7:0] alpha [4];
    bit         alpha_mode;

    // Results still to come, oldest first.
    match_t pending_matches [$];

    int send_idle = 7;
    int recv_idle = 65;
    int cycle_count;
    int error_count;
    int text_count;
    int hit_count;
    int ovf_count;
    int setting_count;
    int random_bytes;
    match_t got;
    match_t want_r;

    last_occurrence_substring_matcher_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // text_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // found, match_position[15:0], overflow, zero pad
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Pattern byte k of the configured registers.
    function automatic logic [7:0] pattern_at(input int k);
        if (k < 8) begin
            return cfg_lo[8*k +: 8];
        end
        if (k < 16) begin
            return cfg_hi[8*(k-8) +: 8];
        end
        return 8'h00;
    endfunction

    // Advance the search by one byte; returns 1 with the result on the final byte.
    function automatic bit search_step(input logic [7:0] b, input logic is_last,
                                       output match_t r);
        bit hit;
        int len;
        len = int'(cfg_len);
        r = '0;
        if (searched >= lossm_pkg::TEXT_MAX) begin
            text_ovf = 1'b1;
        end else begin
            for (int k = lossm_pkg::PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = b;
            searched++;
            if (len != 0 && len <= lossm_pkg::PATTERN_MAX && len <= 16 &&
                searched >= len) begin
                hit = 1'b1;
                for (int j = 0; j < len; j++) begin
                    if (recent[len-1-j] != pattern_at(j)) hit = 1'b0;
                end
                if (hit) begin
                    last_start = searched - len;
                    hit_seen   = 1'b1;
                end
            end
        end
        if (!is_last) return 1'b0;
        r.found = hit_seen;
        if (!hit_seen) r.pos = '0;
        else if (last_start > 16'hFFFF) r.pos = 16'hFFFF;
        else r.pos = last_start[lossm_pkg::POS_W-1:0];
        r.ovf = text_ovf;
        // The text is done: the search state starts over.
        foreach (recent[k]) recent[k] = 8'h00;
        searched   = 0;
        last_start = 0;
        hit_seen   = 1'b0;
        text_ovf   = 1'b0;
        return 1'b1;
    endfunction

    // Offer one byte, wait for the transaction and record what it should produce.
    // Entered and left at a falling edge; valid is left as it is for the caller.
    task automatic send_byte(input logic [7:0] b, input logic is_last,
                             input bit typed, input match_t typed_r);
        match_t r;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (search_step(b, is_last, r)) begin
            if (typed) r = typed_r;
            pending_matches.insert(pending_matches.size(), r);
            text_count++;
            if (r.found) hit_count++;
            if (r.ovf) ovf_count++;
        end
        @(negedge aclk);
    endtask

    task automatic send_text(input int n, input bit typed, input match_t typed_r);
        for (int i = 0; i < n; i++) send_byte(txt[i], i == n - 1, typed, typed_r);
    endtask

    // Stop sending and let every outstanding result drain before touching registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all three pattern registers in turn.
    task automatic write_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [lossm_pkg::LEN_W-1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_index <= lossm_pkg::REG_PAT_FIRST;
        cfg_wdata <= lo;
        @(negedge aclk);
        cfg_index <= lossm_pkg::REG_PAT_LAST;
        cfg_wdata <= hi;
        @(negedge aclk);
        cfg_index <= lossm_pkg::REG_PAT_LEN;
        cfg_wdata <= {{(lossm_pkg::CFG_W-lossm_pkg::LEN_W){1'b0}}, len};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_lo  = lo;
        cfg_hi  = hi;
        cfg_len = len;
        setting_count++;
    endtask

    // Pack the pattern buffer into the two byte registers and write it.
    task automatic load_pattern(input logic [lossm_pkg::LEN_W-1:0] len);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int j = 0; j < 8; j++) begin
            lo[8*j +: 8] = pat_b[j];
            hi[8*j +: 8] = pat_b[j+8];
        end
        write_pattern(lo, hi, len);
    endtask

    // Random text: mostly drawn from a small alphabet with planted, sometimes
    // damaged, copies of the pattern; otherwise plain random bytes.
    task automatic build_text(output int n);
        int copies;
        int at;
        int len;
        len = int'(cfg_len);
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            txt[i] = alpha_mode ? alpha[$urandom_range(3)] : 8'($urandom_range(255));
        end
        copies = (len >= 1 && len <= 16 && len <= n) ? $urandom_range(0, 3) : 0;
        for (int c = 0; c < copies; c++) begin
            at = $urandom_range(0, n - len);
            for (int j = 0; j < len; j++) txt[at+j] = pat_b[j];
            if ($urandom_range(2) == 0) begin
                txt[at + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(7));
            end
        end
    endtask

    // Receiver stalls.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result checking against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tdata[0];
            got.pos   = m_tdata[lossm_pkg::POS_W:1];
            got.ovf   = m_tdata[lossm_pkg::POS_W+1];
            if (pending_matches.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want_r = pending_matches.pop_front();
                if (got.found !== want_r.found) begin
                    $display("%0t ns: found expected %0d actual %0d",
                             $time, want_r.found, got.found);
                    error_count++;
                end
                if (got.pos !== want_r.pos) begin
                    $display("%0t ns: match_position expected %0d actual %0d",
                             $time, want_r.pos, got.pos);
                    error_count++;
                end
                if (got.ovf !== want_r.ovf) begin
                    $display("%0t ns: overflow expected %0d actual %0d",
                             $time, want_r.ovf, got.ovf);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence.
    initial begin
        int n;
        int sel;
        int long_len;
        logic [7:0] b;
        match_t none;

        none = '0;
        cfg_lo = '0;
        cfg_hi = '0;
        cfg_len = '0;
        foreach (recent[k]) recent[k] = 8'h00;
        searched = 0;
        last_start = 0;
        hit_seen = 1'b0;
        text_ovf = 1'b0;
        error_count = 0;
        text_count = 0;
        hit_count = 0;
        ovf_count = 0;
        setting_count = 0;
        random_bytes = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 7 : (phase == 1) ? 65 : 0;
            recv_idle = (phase == 0) ? 65 : (phase == 1) ? 7 : 0;

            // Directed texts first.
            if (phase == 0) begin
                for (int r = 0; r < DIR_ROWS; r++) begin
                    if (dir_rows[r].wr) begin
                        settle();
                        write_pattern(dir_rows[r].lo, dir_rows[r].hi, dir_rows[r].len);
                    end
                    for (int i = 0; i < int'(dir_rows[r].n); i++) begin
                        txt[i] = dir_rows[r].text[8*i +: 8];
                    end
                    send_text(int'(dir_rows[r].n), dir_rows[r].typed, dir_rows[r].want);
                end
            end

            // Random patterns, each searched in a few random texts.
            while (random_bytes < (phase + 1) * RANDOM_BYTES / 3) begin
                settle();
                alpha_mode = ($urandom_range(99) < 60);
                foreach (alpha[k]) alpha[k] = 8'($urandom_range(255));
                foreach (pat_b[k]) begin
                    pat_b[k] = alpha_mode ? alpha[$urandom_range(3)] : 8'($urandom_range(255));
                end
                sel = $urandom_range(99);
                if (sel < 5) load_pattern(5'd0);
                else if (sel < 10) load_pattern(5'($urandom_range(17, 31)));
                else if (sel < 20) load_pattern(5'd16);
                else load_pattern(5'($urandom_range(1, 6)));
                repeat ($urandom_range(2, 6)) begin
                    build_text(n);
                    send_text(n, 1'b0, none);
                    random_bytes += n;
                end
            end
        end

        // Texts at and past the length limit, with hits near the start, right
        // at the limit, and beyond it where they must not count.
        settle();
        foreach (pat_b[k]) pat_b[k] = 8'($urandom_range(255));
        load_pattern(5'd4);
        for (int extra = 0; extra <= 5; extra += 5) begin
            long_len = lossm_pkg::TEXT_MAX + extra;
            for (int i = 0; i < long_len; i++) begin
                if (i >= 100 && i < 104) begin
                    b = pat_b[i-100];
                end else if (i >= lossm_pkg::TEXT_MAX - 4 && i < lossm_pkg::TEXT_MAX) begin
                    b = pat_b[i-(lossm_pkg::TEXT_MAX-4)];
                end else if (i >= lossm_pkg::TEXT_MAX + 1 &&
                             i < lossm_pkg::TEXT_MAX + 5) begin
                    b = pat_b[i-(lossm_pkg::TEXT_MAX+1)];
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_byte(b, i == long_len - 1, 1'b0, none);
            end
        end

        // Drain and let the pipeline go quiet.
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Searched %0d texts over %0d pattern settings, %0d random bytes;",
                 text_count, setting_count, random_bytes);
        $display("%0d texts held a hit and %0d ran past the length limit.",
                 hit_count, ovf_count);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
